// File: src/stok_pkg.sv
// Shared types and codes for the source tokenizer.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package stok_pkg;

  localparam int POS_BITS = 16;   // line and column counter width (8..32)
  localparam int OUT_BITS = 16;   // width of the position ports
  localparam int MAX_TOK  = 3;    // tokens one byte can cause
  localparam int CNT_BITS = $clog2(MAX_TOK + 1);
  localparam int QDEPTH   = 4;    // bundles between front and back
  localparam int QPTR_BITS = $clog2(QDEPTH);

  localparam logic [3:0] KIND_FUNC   = 4'd0;
  localparam logic [3:0] KIND_VAR    = 4'd1;
  localparam logic [3:0] KIND_IDENT  = 4'd2;
  localparam logic [3:0] KIND_INT    = 4'd3;
  localparam logic [3:0] KIND_LPAREN = 4'd4;
  localparam logic [3:0] KIND_RPAREN = 4'd5;
  localparam logic [3:0] KIND_LBRACE = 4'd6;
  localparam logic [3:0] KIND_RBRACE = 4'd7;
  localparam logic [3:0] KIND_SEMI   = 4'd8;
  localparam logic [3:0] KIND_COLON  = 4'd9;
  localparam logic [3:0] KIND_EQUAL  = 4'd10;
  localparam logic [3:0] KIND_END    = 4'd11;
  localparam logic [3:0] KIND_ERR    = 4'd12;

  typedef struct packed {
    logic [3:0]          kind;
    logic [POS_BITS-1:0] line;
    logic [POS_BITS-1:0] scol;
    logic [POS_BITS-1:0] ecol;
  } tok_t;

  // All tokens caused by one accepted byte.
  typedef struct packed {
    logic [CNT_BITS-1:0]    cnt;
    tok_t [MAX_TOK-1:0]     tok;
  } bundle_t;

endpackage

// File: src/stok_front.sv
// Front end: accepts source bytes, tracks position and scanner state,
// and builds the bundle of tokens each byte causes. Uses stok_pkg.
`timescale 1ns / 1ps

module stok_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        char_code,
  input  logic              last_byte,
  output logic              bundle_wr,
  output stok_pkg::bundle_t bundle
);
  import stok_pkg::*;

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_IDENT = 2'd1;
  localparam logic [1:0] M_INT   = 2'd2;
  localparam logic [1:0] M_SKIP  = 2'd3;

  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_F    = 3'd1;
  localparam logic [2:0] KW_FU   = 3'd2;
  localparam logic [2:0] KW_FUN  = 3'd3;
  localparam logic [2:0] KW_FUNC = 3'd4;
  localparam logic [2:0] KW_V    = 3'd5;
  localparam logic [2:0] KW_VA   = 3'd6;
  localparam logic [2:0] KW_VAR  = 3'd7;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_US  = 8'h5F;

  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic [1:0]          mode, mode_next;
  logic [2:0]          kw, kw_next;
  logic [POS_BITS-1:0] line, line_next;
  logic [POS_BITS-1:0] col, col_next;
  logic [POS_BITS-1:0] sline, sline_next;
  logic [POS_BITS-1:0] scol, scol_next;

  logic letter, digit, space, word_ch;
  logic [3:0] pkind;
  logic       is_punct;
  tok_t [MAX_TOK-1:0] slots;
  logic [CNT_BITS-1:0] n;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] x);
    sat_inc = (x == POS_MAX) ? POS_MAX : x + POS_ONE;
  endfunction

  function automatic tok_t close_tok(input logic [1:0] m, input logic [2:0] k,
                                     input logic [POS_BITS-1:0] sl,
                                     input logic [POS_BITS-1:0] sc,
                                     input logic [POS_BITS-1:0] cc);
    tok_t t;
    t.line = sl;
    t.scol = sc;
    // end column is one before the current column, never before the start
    t.ecol = (cc > sc) ? cc - POS_ONE : sc;
    if (m == M_INT) t.kind = KIND_INT;
    else if (k == KW_FUNC) t.kind = KIND_FUNC;
    else if (k == KW_VAR) t.kind = KIND_VAR;
    else t.kind = KIND_IDENT;
    return t;
  endfunction

  function automatic tok_t point_tok(input logic [3:0] k,
                                     input logic [POS_BITS-1:0] l,
                                     input logic [POS_BITS-1:0] c);
    tok_t t;
    t.kind = k;
    t.line = l;
    t.scol = c;
    t.ecol = c;
    return t;
  endfunction

  function automatic logic [2:0] kw_step(input logic [2:0] p, input logic [7:0] c);
    kw_step = KW_NONE;
    if (p == KW_F   && c == "u") kw_step = KW_FU;
    if (p == KW_FU  && c == "n") kw_step = KW_FUN;
    if (p == KW_FUN && c == "c") kw_step = KW_FUNC;
    if (p == KW_V   && c == "a") kw_step = KW_VA;
    if (p == KW_VA  && c == "r") kw_step = KW_VAR;
  endfunction

  always_comb begin
    letter  = (char_code >= "a" && char_code <= "z") ||
              (char_code >= "A" && char_code <= "Z");
    digit   = (char_code >= "0" && char_code <= "9");
    space   = (char_code == " ") || (char_code >= 8'd9 && char_code <= 8'd13);
    word_ch = letter || digit || (char_code == CH_US);
    is_punct = 1'b1;
    unique case (char_code)
      "(":     pkind = KIND_LPAREN;
      ")":     pkind = KIND_RPAREN;
      "{":     pkind = KIND_LBRACE;
      "}":     pkind = KIND_RBRACE;
      ";":     pkind = KIND_SEMI;
      ":":     pkind = KIND_COLON;
      "=":     pkind = KIND_EQUAL;
      default: begin
        pkind    = KIND_ERR;
        is_punct = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_next  = mode;
    kw_next    = kw;
    line_next  = line;
    col_next   = col;
    sline_next = sline;
    scol_next  = scol;
    slots      = '0;
    n          = '0;

    if (mode == M_SKIP) begin
      mode_next = mode;
    end else if (char_code == CH_NUL) begin
      if (mode == M_IDENT || mode == M_INT) begin
        slots[n] = close_tok(mode, kw, sline, scol, col);
        n = n + 1'b1;
      end
      slots[n] = point_tok(KIND_END, line, col);
      n = n + 1'b1;
      mode_next = M_SKIP;
      kw_next   = KW_NONE;
    end else begin
      if (mode == M_IDENT && word_ch) begin
        kw_next  = kw_step(kw, char_code);
        col_next = sat_inc(col);
      end else if (mode == M_INT && digit) begin
        col_next = sat_inc(col);
      end else begin
        if (mode == M_IDENT || mode == M_INT) begin
          slots[n] = close_tok(mode, kw, sline, scol, col);
          n = n + 1'b1;
        end
        mode_next = M_IDLE;
        kw_next   = KW_NONE;
        if (space) begin
          if (char_code == CH_LF) begin
            line_next = sat_inc(line);
            col_next  = POS_ONE;
          end else begin
            col_next = sat_inc(col);
          end
        end else if (letter || char_code == CH_US) begin
          mode_next  = M_IDENT;
          sline_next = line;
          scol_next  = col;
          kw_next    = (char_code == "f") ? KW_F : (char_code == "v") ? KW_V : KW_NONE;
          col_next   = sat_inc(col);
        end else if (digit) begin
          mode_next  = M_INT;
          sline_next = line;
          scol_next  = col;
          col_next   = sat_inc(col);
        end else if (is_punct) begin
          slots[n] = point_tok(pkind, line, col);
          n = n + 1'b1;
          col_next = sat_inc(col);
        end else begin
          slots[n] = point_tok(KIND_ERR, line, col);
          n = n + 1'b1;
          mode_next = M_SKIP;
        end
      end
      // final byte: flush what is pending with the updated position
      if (last_byte && mode_next != M_SKIP) begin
        if (mode_next == M_IDENT || mode_next == M_INT) begin
          slots[n] = close_tok(mode_next, kw_next, sline_next, scol_next, col_next);
          n = n + 1'b1;
        end
        slots[n] = point_tok(KIND_END, line_next, col_next);
        n = n + 1'b1;
      end
    end

    if (last_byte) begin
      mode_next  = M_IDLE;
      kw_next    = KW_NONE;
      line_next  = POS_ONE;
      col_next   = POS_ONE;
      sline_next = '0;
      scol_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      kw    <= KW_NONE;
      line  <= POS_ONE;
      col   <= POS_ONE;
      sline <= '0;
      scol  <= '0;
    end else if (in_valid) begin
      mode  <= mode_next;
      kw    <= kw_next;
      line  <= line_next;
      col   <= col_next;
      sline <= sline_next;
      scol  <= scol_next;
    end
  end

  assign bundle_wr  = in_valid && (n != '0);
  assign bundle.cnt = n;
  assign bundle.tok = slots;

  // skipping bytes never move the position unless they end the source
  a_skip_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && mode == M_SKIP && !last_byte) |=> ($stable(line) && $stable(col)))
    else $error("position moved while skipping");

  // a skipping byte never produces tokens
  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    (mode == M_SKIP) |-> !bundle_wr)
    else $error("token emitted while skipping");

endmodule

// File: src/stok_fifo.sv
// Short bundle queue between the front and back ends.
// Uses stok_pkg for the bundle type and depth.
`timescale 1ns / 1ps

module stok_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  stok_pkg::bundle_t wdata,
  output logic              full,
  input  logic              rd,
  output stok_pkg::bundle_t rdata,
  output logic              empty
);
  import stok_pkg::*;

  bundle_t mem [QDEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QPTR_BITS:0]   count;

  assign full  = (count == (QPTR_BITS + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (QPTR_BITS + 1)'(wr) - (QPTR_BITS + 1)'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> (!full || rd))
    else $error("bundle written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty)
    else $error("bundle read from an empty queue");

endmodule

// File: src/stok_back.sv
// Back end: takes bundles from the queue and hands out one token word
// per cycle while pop is held, from a registered bundle. Uses stok_pkg.
`timescale 1ns / 1ps

module stok_back (
  input  logic                        clk,
  input  logic                        rst,
  input  stok_pkg::bundle_t           q_data,
  input  logic                        q_empty,
  output logic                        q_rd,
  output logic                        empty,
  input  logic                        pop,
  output logic [3:0]                  token_kind,
  output logic [stok_pkg::OUT_BITS-1:0] token_line,
  output logic [stok_pkg::OUT_BITS-1:0] start_column,
  output logic [stok_pkg::OUT_BITS-1:0] end_column,
  output logic                        last_of_run
);
  import stok_pkg::*;

  bundle_t             cur;
  logic                cur_valid;
  logic [CNT_BITS-1:0] idx;
  logic                taken, at_end;
  tok_t                t;

  assign taken  = pop && cur_valid;
  assign at_end = (idx == cur.cnt - 1'b1);
  assign q_rd   = !q_empty && (!cur_valid || (taken && at_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (taken && !at_end) begin
      idx <= idx + 1'b1;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (taken) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) cur <= q_data;
  end

  assign t            = cur.tok[idx];
  assign empty        = !cur_valid;
  assign token_kind   = t.kind;
  assign token_line   = OUT_BITS'(t.line);
  assign start_column = OUT_BITS'(t.scol);
  assign end_column   = OUT_BITS'(t.ecol);
  assign last_of_run  = at_end;

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.cnt != '0 && idx < cur.cnt))
    else $error("token index outside its bundle");

  a_hold_unpopped: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !pop) |=> (cur_valid && $stable(idx)))
    else $error("waiting token word changed without a pop");

endmodule

// File: src/source_tokenizer.sv
// Top level of the source tokenizer: front end, bundle queue, back end.
// Uses stok_pkg, stok_front, stok_fifo and stok_back.
//
//   channel  direction  handshake      payload
//   byte     in         push / full    char_code, last_byte
//   token    out        pop / empty    token_kind, token_line, start_column,
//                                      end_column, last_of_run
//
// One byte is accepted per cycle while the four-bundle queue has room.
// The back end delivers one token word per cycle while pop is held, so a byte
// with more than one token holds it until all are popped; the queue absorbs
// such bursts. A token reaches the ports via the queue memory and then the
// back end's bundle register. Reset is synchronous; no clearing pass follows.
// A stalled output fills the queue and then raises full.
`timescale 1ns / 1ps

module source_tokenizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    char_code,
  input  logic                          last_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [3:0]                    token_kind,
  output logic [stok_pkg::OUT_BITS-1:0] token_line,
  output logic [stok_pkg::OUT_BITS-1:0] start_column,
  output logic [stok_pkg::OUT_BITS-1:0] end_column,
  output logic                          last_of_run
);
  import stok_pkg::*;

  logic    accept;
  logic    b_wr;
  bundle_t b_data;
  bundle_t q_data;
  logic    q_empty, q_rd;

  assign accept = push && !full;

  stok_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .char_code (char_code),
    .last_byte (last_byte),
    .bundle_wr (b_wr),
    .bundle    (b_data)
  );

  stok_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (b_wr),
    .wdata (b_data),
    .full  (full),
    .rd    (q_rd),
    .rdata (q_data),
    .empty (q_empty)
  );

  stok_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_data),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .token_kind   (token_kind),
    .token_line   (token_line),
    .start_column (start_column),
    .end_column   (end_column),
    .last_of_run  (last_of_run)
  );

endmodule

// File: bench/token_checker.sv
// Token checker for the source tokenizer: follows the byte and token channels,
// predicts every token word from the accepted bytes and compares in order.
// Depends on stok_pkg for token kinds and port widths.
`timescale 1ns / 1ps

module token_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic [7:0]                    char_code,
  input  logic                          last_byte,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [3:0]                    token_kind,
  input  logic [stok_pkg::OUT_BITS-1:0] token_line,
  input  logic [stok_pkg::OUT_BITS-1:0] start_column,
  input  logic [stok_pkg::OUT_BITS-1:0] end_column,
  input  logic                          last_of_run,
  output int                            fails,
  output int                            waiting,
  output int                            checked
);
  import stok_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [POS_BITS-1:0] POS_TOP = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  typedef enum logic [1:0] {SCAN_GAP, SCAN_NAME, SCAN_NUMBER, SCAN_SKIP} scan_e;
  typedef enum logic [2:0] {KW_NONE, KW_F, KW_FU, KW_FUN, KW_FUNC, KW_V, KW_VA, KW_VAR} kw_e;

  typedef struct packed {
    logic [3:0]          kind;
    logic [OUT_BITS-1:0] line;
    logic [OUT_BITS-1:0] scol;
    logic [OUT_BITS-1:0] ecol;
    logic                fin;
  } token_word_t;

  scan_e               mode;
  kw_e                 kw;
  logic [POS_BITS-1:0] cur_line, cur_col, tok_line, tok_col;
  token_word_t         due_q[$];
  int                  fail_cnt, tok_cnt;

  function automatic logic [POS_BITS-1:0] bump(input logic [POS_BITS-1:0] v);
    return (v == POS_TOP) ? v : v + 1'b1;
  endfunction

  function automatic void clear_scan();
    mode = SCAN_GAP;
    kw = KW_NONE;
    cur_line = POS_ONE;
    cur_col = POS_ONE;
    tok_line = '0;
    tok_col = '0;
  endfunction

  function automatic void emit_token(input logic [3:0] kind, input logic [POS_BITS-1:0] ln,
                                     input logic [POS_BITS-1:0] s,
                                     input logic [POS_BITS-1:0] e);
    token_word_t w;
    w.kind = kind;
    w.line = OUT_BITS'(ln);
    w.scol = OUT_BITS'(s);
    w.ecol = OUT_BITS'(e);
    w.fin = 1'b0;
    due_q.push_back(w);
  endfunction

  function automatic void advance(input logic [7:0] c);
    if (c == CH_LF) begin
      cur_line = bump(cur_line);
      cur_col = POS_ONE;
    end else begin
      cur_col = bump(cur_col);
    end
  endfunction

  // end column never drops below the start, so it falls short once saturated
  function automatic void close_open();
    logic [POS_BITS-1:0] e;
    logic [3:0]          kind;
    if (mode == SCAN_NAME || mode == SCAN_NUMBER) begin
      e = (cur_col > tok_col) ? cur_col - 1'b1 : tok_col;
      if (mode == SCAN_NUMBER) kind = KIND_INT;
      else if (kw == KW_FUNC) kind = KIND_FUNC;
      else if (kw == KW_VAR) kind = KIND_VAR;
      else kind = KIND_IDENT;
      emit_token(kind, tok_line, tok_col, e);
      mode = SCAN_GAP;
      kw = KW_NONE;
    end
  endfunction

  function automatic kw_e kw_step(input kw_e p, input logic [7:0] c);
    case (p)
      KW_F:    return (c == "u") ? KW_FU : KW_NONE;
      KW_FU:   return (c == "n") ? KW_FUN : KW_NONE;
      KW_FUN:  return (c == "c") ? KW_FUNC : KW_NONE;
      KW_V:    return (c == "a") ? KW_VA : KW_NONE;
      KW_VA:   return (c == "r") ? KW_VAR : KW_NONE;
      default: return KW_NONE;
    endcase
  endfunction

  // KIND_ERR doubles as "not punctuation"
  function automatic logic [3:0] punct_code(input logic [7:0] c);
    case (c)
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      ";":     return KIND_SEMI;
      ":":     return KIND_COLON;
      "=":     return KIND_EQUAL;
      default: return KIND_ERR;
    endcase
  endfunction

  function automatic void scan_byte(input logic [7:0] c, input logic lst);
    logic        letter, digit, space;
    logic [3:0]  pk;
    int          n0;
    token_word_t w;
    letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    digit = (c >= "0" && c <= "9");
    space = (c == " ") || (c >= CH_TAB && c <= CH_CR);
    n0 = due_q.size();
    if (mode == SCAN_SKIP) begin
      if (lst) clear_scan();
    end else if (c == CH_NUL) begin
      // zero byte is not consumed; it ends the source where it stands
      close_open();
      emit_token(KIND_END, cur_line, cur_col, cur_col);
      if (lst) clear_scan();
      else mode = SCAN_SKIP;
    end else begin
      if (mode == SCAN_NAME && (letter || digit || c == "_")) begin
        kw = kw_step(kw, c);
        advance(c);
      end else if (mode == SCAN_NUMBER && digit) begin
        advance(c);
      end else begin
        close_open();
        pk = punct_code(c);
        if (space) begin
          advance(c);
        end else if (letter || c == "_") begin
          mode = SCAN_NAME;
          tok_line = cur_line;
          tok_col = cur_col;
          kw = (c == "f") ? KW_F : (c == "v") ? KW_V : KW_NONE;
          advance(c);
        end else if (digit) begin
          mode = SCAN_NUMBER;
          tok_line = cur_line;
          tok_col = cur_col;
          kw = KW_NONE;
          advance(c);
        end else if (pk != KIND_ERR) begin
          emit_token(pk, cur_line, cur_col, cur_col);
          advance(c);
        end else begin
          emit_token(KIND_ERR, cur_line, cur_col, cur_col);
          mode = SCAN_SKIP;
        end
      end
      if (lst) begin
        if (mode != SCAN_SKIP) begin
          close_open();
          emit_token(KIND_END, cur_line, cur_col, cur_col);
        end
        clear_scan();
      end
    end
    if (due_q.size() > n0) begin
      w = due_q.pop_back();
      w.fin = 1'b1;
      due_q.push_back(w);
    end
  endfunction

  function automatic void check_token();
    token_word_t got, want;
    got = {token_kind, token_line, start_column, end_column, last_of_run};
    tok_cnt++;
    if (due_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("token word %0d with none expected: kind=%0d line=%0d cols=%0d..%0d last=%0b",
                 tok_cnt, got.kind, got.line, got.scol, got.ecol, got.fin);
    end else begin
      want = due_q.pop_front();
      if (got !== want) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
          $display("token word %0d: want kind=%0d line=%0d cols=%0d..%0d last=%0b",
                   tok_cnt, want.kind, want.line, want.scol, want.ecol, want.fin);
          $display("                 got  kind=%0d line=%0d cols=%0d..%0d last=%0b",
                   got.kind, got.line, got.scol, got.ecol, got.fin);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      due_q.delete();
      fail_cnt = 0;
      tok_cnt = 0;
      fails <= 0;
      waiting <= 0;
      checked <= 0;
    end else begin
      if (push && !full) scan_byte(char_code, last_byte);
      if (pop && !empty) check_token();
      fails <= fail_cnt;
      waiting <= due_q.size();
      checked <= tok_cnt;
    end
  end

endmodule

// File: bench/tb_top.sv
// Testbench top for source_tokenizer: clock, reset, byte stimulus, token pops.
// Depends on stok_pkg, source_tokenizer and token_checker.
`timescale 1ns / 1ps

module tb_top;
  import stok_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE = 20;
  localparam int RANDOM_BYTES = 450;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  logic                clk;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          char_code = 8'h00;
  logic                last_byte = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [3:0]          token_kind;
  logic [OUT_BITS-1:0] token_line, start_column, end_column;
  logic                last_of_run;
  int                  fails, waiting, checked;

  bit                  tx_idle, rx_idle;
  logic [7:0]          src_q[$];
  int                  sent_live, n_sources, idle_cycles;

  source_tokenizer dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .char_code(char_code), .last_byte(last_byte),
    .empty(empty), .pop(pop), .token_kind(token_kind), .token_line(token_line),
    .start_column(start_column), .end_column(end_column), .last_of_run(last_of_run)
  );

  token_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .char_code(char_code), .last_byte(last_byte),
    .empty(empty), .pop(pop), .token_kind(token_kind), .token_line(token_line),
    .start_column(start_column), .end_column(end_column), .last_of_run(last_of_run),
    .fails(fails), .waiting(waiting), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // token side: pop every cycle, with stall bursts while rx_idle is set
  initial begin
    forever begin
      @(posedge clk);
      if (rx_idle && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic lst);
    if (tx_idle && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push <= 1'b1;
    char_code <= c;
    last_byte <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // sends src_q with the final byte marked last; live = bytes not ignored
  task automatic send_src(input int live);
    for (int i = 0; i < src_q.size(); i++) send_byte(src_q[i], i == src_q.size() - 1);
    sent_live += live;
    n_sources++;
    src_q.delete();
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_name_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 5))
      0:       return " ";
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(0, 6))
      0:       return "(";
      1:       return ")";
      2:       return "{";
      3:       return "}";
      4:       return ";";
      5:       return ":";
      default: return "=";
    endcase
  endfunction

  // nonzero byte the tokenizer knows how to handle
  function automatic bit plain_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "_" || c == " " || (c >= CH_TAB && c <= CH_CR) ||
           c == "(" || c == ")" || c == "{" || c == "}" || c == ";" || c == ":" || c == "=";
  endfunction

  function automatic logic [7:0] odd_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (plain_byte(c));
    return c;
  endfunction

  task automatic add_token();
    int n;
    case ($urandom_range(0, 9))
      0: append_text("func");
      1: append_text("var");
      2: begin
        case ($urandom_range(0, 7))
          0:       append_text("f");
          1:       append_text("fu");
          2:       append_text("fun");
          3:       append_text("funcs");
          4:       append_text("v");
          5:       append_text("va");
          6:       append_text("vars");
          default: append_text("Func");
        endcase
      end
      3, 4: begin
        n = $urandom_range(0, 5);
        src_q.push_back(rand_name_char(1'b1));
        repeat (n) src_q.push_back(rand_name_char(1'b0));
      end
      5: begin
        n = $urandom_range(1, 5);
        repeat (n) src_q.push_back(8'("0" + $urandom_range(0, 9)));
      end
      6, 7: src_q.push_back(rand_punct());
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) src_q.push_back(rand_space());
      end
      default: src_q.push_back(CH_LF);
    endcase
  endtask

  task automatic make_clean_source();
    int ntok;
    ntok = $urandom_range(1, 12);
    repeat (ntok) begin
      add_token();
      if ($urandom_range(0, 1)) src_q.push_back(rand_space());
    end
    if ($urandom_range(0, 3) == 0) src_q.push_back(CH_NUL);
    send_src(src_q.size());
  endtask

  // zero or unknown byte mid-source; a trail of 0 makes it the last byte
  task automatic make_broken_source();
    int ntok, trail, live;
    ntok = $urandom_range(0, 4);
    repeat (ntok) add_token();
    src_q.push_back($urandom_range(0, 1) ? CH_NUL : odd_byte());
    live = src_q.size();
    trail = $urandom_range(0, 4);
    repeat (trail) src_q.push_back(8'($urandom_range(0, 255)));
    send_src(live);
  endtask

  task automatic make_noise_source();
    int         k, live;
    bit         stop;
    logic [7:0] c;
    k = $urandom_range(1, 6);
    live = 0;
    stop = 1'b0;
    repeat (k) begin
      c = 8'($urandom_range(0, 255));
      src_q.push_back(c);
      if (!stop) begin
        live++;
        if (!plain_byte(c)) stop = 1'b1;
      end
    end
    send_src(live);
  endtask

  initial begin
    int pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: keywords, all punctuation, every whitespace, end marks, bad bytes
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    append_text("func(_){var:;=0}");
    send_src(src_q.size());
    src_q = {" ", CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_NUL};
    send_src(src_q.size());
    append_text("Zz9");
    src_q.push_back(CH_NUL);
    src_q.push_back(8'h80);
    send_src(4);
    append_text("9");
    src_q.push_back(8'hFF);
    send_src(2);
    append_text("x#y");
    send_src(2);
    hold_until_drained();

    while (sent_live < RANDOM_BYTES) begin
      tx_idle = (sent_live < 120) || (sent_live >= 180 && sent_live < 360);
      rx_idle = (sent_live < 120) || (sent_live >= 240 && sent_live < 360);
      pick = $urandom_range(0, 9);
      if (pick <= 6) make_clean_source();
      else if (pick <= 8) make_broken_source();
      else make_noise_source();
      if (n_sources % 20 == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d live bytes in %0d sources: keywords, names, numbers, punctuation,",
             sent_live, n_sources);
    $display("whitespace, end marks and bad bytes; %0d token words checked", checked);
    if (fails == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
